@@ sv/ddps_pkg.sv @@
package ddps_pkg;

   // error, power, sum and fraction widths
   localparam int ERR_W = 26;
   localparam int PWR_W = 23;
   localparam int SUM_W = 38;
   localparam int FRAC_W = 16;

   // configuration register indexes
   localparam logic [2:0] CSR_TARGET      = 3'd0;
   localparam logic [2:0] CSR_MAX_POWER   = 3'd1;
   localparam logic [2:0] CSR_REVERSED    = 3'd2;
   localparam logic [2:0] CSR_CURVE       = 3'd3;
   localparam logic [2:0] CSR_CURVE_RIGHT = 3'd4;
   localparam logic [2:0] CSR_TIMEOUT     = 3'd5;
   localparam logic [2:0] CSR_KP          = 3'd6;
   localparam logic [2:0] CSR_SETTLE      = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // request operations
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_RUNNING   = 2'd0;
   localparam logic [1:0] STATUS_SETTLED   = 2'd1;
   localparam logic [1:0] STATUS_TIMED_OUT = 2'd2;
   localparam logic [1:0] STATUS_IDLE      = 2'd3;

   // degrees to q8 inch, q16 scaled: round(pi/90 * 256 * 65536)
   localparam logic signed [ERR_W-1:0] DEG_TO_Q8 = 26'sd585635;
   localparam logic signed [ERR_W-1:0] ERR_MAX   = 26'sh1FFFFFF;
   localparam logic signed [ERR_W-1:0] ERR_MIN   = 26'sh2000000;
   localparam logic signed [ERR_W-1:0] BAND_Q8   = 26'sd128;
   localparam int OFFSET_A_Q16 = 15 * 65536;
   localparam int OFFSET_B     = 20;

   // reset values of configuration registers and counter limits
   localparam logic [6:0]  MAX_POWER_RST = 7'd127;
   localparam logic [15:0] TIMEOUT_RST   = 16'd250;
   localparam logic [9:0]  KP_RST        = 10'd154;
   localparam logic [5:0]  SETTLE_RST    = 6'd26;
   localparam logic [5:0]  BAND_CNT_MAX  = 6'd63;
   localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

   typedef struct packed {
      logic load_req;
      logic step_mag;
      logic step_lo;
      logic step_hi;
      logic step_pos;
      logic step_err;
      logic step_kp;
      logic step_sum;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic active;
   } stat_type;

   function automatic logic signed [7:0] sat127(input logic signed [PWR_W:0] v);
      logic signed [7:0] r;
      if (v > 24'sd127) begin
         r = 8'sd127;
      end else if (v < -24'sd127) begin
         r = -8'sd127;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

@@ sv/drive_distance_pd_settle.sv @@
// tick beat while moving: the sequencer runs magnitude, lo, hi, position,
// error, kp and sum steps, three passes through the one shared multiplier,
// then the finish step, which waits until the output register is free
// start beat or tick while idle: straight to the finish step; a new beat waits until it ends
// reset (synchronous, active high) clears the move to idle, empties the output
// register and loads the configuration registers with their default values
module drive_distance_pd_settle #(
   parameter int ENCODER_WIDTH = 21
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic signed [ENCODER_WIDTH-1:0]  req_encoder_degrees,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [7:0]                rsp_left_power,
   output logic signed [7:0]                rsp_right_power,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_wen,
   input  logic [ddps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ddps_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ddps_pkg::cmd_type  cmd;
   ddps_pkg::stat_type stat;

   ddps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ddps_datapath #(
      .ENCODER_WIDTH (ENCODER_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_op              (req_op),
      .req_encoder_degrees (req_encoder_degrees),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_left_power      (rsp_left_power),
      .rsp_right_power     (rsp_right_power),
      .rsp_status          (rsp_status)
   );

endmodule

@@ sv/ddps_ctrl.sv @@
module ddps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ddps_pkg::stat_type stat,
   output ddps_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MAG  = 4'd1;
   localparam logic [3:0] S_LO   = 4'd2;
   localparam logic [3:0] S_HI   = 4'd3;
   localparam logic [3:0] S_POS  = 4'd4;
   localparam logic [3:0] S_ERR  = 4'd5;
   localparam logic [3:0] S_KP   = 4'd6;
   localparam logic [3:0] S_SUM  = 4'd7;
   localparam logic [3:0] S_FIN  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // start beats and ticks while idle skip the datapath passes
               if (req_op == ddps_pkg::OP_START || !stat.active) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_MAG;
               end
            end
         end
         S_MAG: state_in = S_LO;
         S_LO:  state_in = S_HI;
         S_HI:  state_in = S_POS;
         S_POS: state_in = S_ERR;
         S_ERR: state_in = S_KP;
         S_KP:  state_in = S_SUM;
         S_SUM: state_in = S_FIN;
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.load_req = accept;
      cmd.step_mag = (state_ff == S_MAG);
      cmd.step_lo  = (state_ff == S_LO);
      cmd.step_hi  = (state_ff == S_HI);
      cmd.step_pos = (state_ff == S_POS);
      cmd.step_err = (state_ff == S_ERR);
      cmd.step_kp  = (state_ff == S_KP);
      cmd.step_sum = (state_ff == S_SUM);
      cmd.finish   = (state_ff == S_FIN) && out_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/ddps_datapath.sv @@
module ddps_datapath #(
   parameter int ENCODER_WIDTH = 21
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_op,
   input  logic signed [ENCODER_WIDTH-1:0]      req_encoder_degrees,
   input  logic                                 csr_wen,
   input  logic [ddps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ddps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  ddps_pkg::cmd_type                    cmd,
   output ddps_pkg::stat_type                   stat,
   output logic signed [7:0]                    rsp_left_power,
   output logic signed [7:0]                    rsp_right_power,
   output logic [1:0]                           rsp_status
);

   localparam int EW    = ENCODER_WIDTH;
   localparam int MAGW  = EW + 1;
   localparam int HIW   = (MAGW > 16) ? MAGW - 16 : 1;
   localparam int MAGPW = 16 + HIW;
   localparam int MULAW = (HIW > 16) ? HIW : 16;
   localparam int PRODW = MULAW + ddps_pkg::ERR_W + 1;
   localparam int POSMW = EW + 4;
   localparam int EFW   = ((EW + 5 > ddps_pkg::ERR_W) ? EW + 5 : ddps_pkg::ERR_W) + 1;
   localparam int ERRW  = ddps_pkg::ERR_W;
   localparam int PWRW  = ddps_pkg::PWR_W;
   localparam int SUMW  = ddps_pkg::SUM_W;

   // configuration registers
   logic signed [23:0] target_ff;
   logic [6:0]         maxp_ff;
   logic               rev_ff;
   logic [6:0]         curve_ff;
   logic               curve_right_ff;
   logic [15:0]        timeout_ff;
   logic [9:0]         kp_ff;
   logic [5:0]         settle_ff;

   // move state
   logic signed [EW-1:0]   zero_ff;
   logic signed [ERRW-1:0] last_ff;
   logic [5:0]             band_cnt_ff;
   logic [15:0]            elapsed_ff;
   logic                   active_ff;

   // captured beat and working registers
   logic                   op_ff;
   logic signed [EW-1:0]   enc_ff;
   logic [MAGPW-1:0]       mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic signed [PRODW-1:0] prod_ff, prod_in;
   logic [19:0]            lo_sh_ff;
   logic signed [POSMW:0]  pos_ff, pos_in;
   logic signed [ERRW-1:0] err_ff, err_in;
   logic signed [PWRW-1:0] power_ff, power_in;

   logic signed [7:0] left_ff, left_in;
   logic signed [7:0] right_ff, right_in;
   logic [1:0]        status_ff, status_in;

   assign stat.active     = active_ff;
   assign rsp_left_power  = left_ff;
   assign rsp_right_power = right_ff;
   assign rsp_status      = status_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff      <= '0;
         maxp_ff        <= ddps_pkg::MAX_POWER_RST;
         rev_ff         <= 1'b0;
         curve_ff       <= '0;
         curve_right_ff <= 1'b0;
         timeout_ff     <= ddps_pkg::TIMEOUT_RST;
         kp_ff          <= ddps_pkg::KP_RST;
         settle_ff      <= ddps_pkg::SETTLE_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            ddps_pkg::CSR_TARGET:      target_ff      <= csr_wdata;
            ddps_pkg::CSR_MAX_POWER:   maxp_ff        <= csr_wdata[6:0];
            ddps_pkg::CSR_REVERSED:    rev_ff         <= csr_wdata[0];
            ddps_pkg::CSR_CURVE:       curve_ff       <= csr_wdata[6:0];
            ddps_pkg::CSR_CURVE_RIGHT: curve_right_ff <= csr_wdata[0];
            ddps_pkg::CSR_TIMEOUT:     timeout_ff     <= csr_wdata[15:0];
            ddps_pkg::CSR_KP:          kp_ff          <= csr_wdata[9:0];
            ddps_pkg::CSR_SETTLE:      settle_ff      <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // travel since zero point, as sign and magnitude
   logic signed [MAGW-1:0] delta;
   always_comb begin
      delta  = MAGW'(enc_ff) - MAGW'(zero_ff);
      neg_in = delta[MAGW-1];
      mag_in = MAGPW'(neg_in ? -delta : delta);
   end

   // shared multiplier: two passes for position, one for kp * error
   logic [MULAW-1:0]       mul_a;
   logic signed [ERRW-1:0] mul_b;
   always_comb begin
      if (cmd.step_lo) begin
         mul_a = MULAW'(mag_ff[15:0]);
         mul_b = ddps_pkg::DEG_TO_Q8;
      end else if (cmd.step_hi) begin
         mul_a = MULAW'(mag_ff[MAGPW-1:16]);
         mul_b = ddps_pkg::DEG_TO_Q8;
      end else begin
         mul_a = MULAW'(kp_ff);
         mul_b = err_ff;
      end
      prod_in = $signed({1'b0, mul_a}) * mul_b;
   end

   // (mag * c) >> 16 = hi * c + ((lo * c) >> 16)
   logic [PRODW-1:0]   pos_sum;
   logic [POSMW-1:0]   pos_mag;
   always_comb begin
      pos_sum = $unsigned(prod_ff) + PRODW'(lo_sh_ff);
      pos_mag = pos_sum[POSMW-1:0];
      pos_in  = neg_ff ? -$signed({1'b0, pos_mag}) : $signed({1'b0, pos_mag});
   end

   logic signed [EFW-1:0] err_full;
   always_comb begin
      err_full = EFW'(target_ff) - EFW'(pos_ff);
      if (err_full > EFW'(ddps_pkg::ERR_MAX)) begin
         err_in = ddps_pkg::ERR_MAX;
      end else if (err_full < EFW'(ddps_pkg::ERR_MIN)) begin
         err_in = ddps_pkg::ERR_MIN;
      end else begin
         err_in = err_full[ERRW-1:0];
      end
   end

   // pd sum in q16, truncated toward zero
   logic signed [ERRW:0]   diff;
   logic signed [SUMW-1:0] sum;
   logic signed [SUMW-1:0] sum_sh;
   logic                   round_up;
   always_comb begin
      diff     = (ERRW + 1)'(err_ff) - (ERRW + 1)'(last_ff);
      sum      = SUMW'(prod_ff) + (SUMW'(diff) <<< 8) + SUMW'(ddps_pkg::OFFSET_A_Q16);
      sum_sh   = sum >>> ddps_pkg::FRAC_W;
      round_up = sum[SUMW-1] && (sum[ddps_pkg::FRAC_W-1:0] != '0);
      power_in = PWRW'(sum_sh) + PWRW'(round_up) + PWRW'(ddps_pkg::OFFSET_B);
   end

   // finish: clamp, reverse, curve, settle and timeout
   logic signed [PWRW-1:0] maxp_s, pw_clamp, pw_rev;
   logic signed [PWRW:0]   curve_s, curved, other;
   logic                   in_band, settled, timed_out;
   logic [5:0]             cnt_next;
   logic [15:0]            elapsed_next;
   always_comb begin
      maxp_s   = PWRW'($signed({1'b0, maxp_ff}));
      curve_s  = (PWRW + 1)'($signed({1'b0, curve_ff}));
      pw_clamp = (power_ff > maxp_s) ? maxp_s : power_ff;
      pw_rev   = rev_ff ? -pw_clamp : pw_clamp;
      other    = (PWRW + 1)'(pw_rev);
      curved   = (pw_rev > 0) ? other - curve_s : other + curve_s;

      in_band      = (err_ff < ddps_pkg::BAND_Q8) && (err_ff > -ddps_pkg::BAND_Q8);
      cnt_next     = (band_cnt_ff == ddps_pkg::BAND_CNT_MAX) ? band_cnt_ff
                                                             : band_cnt_ff + 6'd1;
      elapsed_next = (elapsed_ff == ddps_pkg::ELAPSED_MAX) ? elapsed_ff
                                                           : elapsed_ff + 16'd1;
      settled      = in_band && (cnt_next >= settle_ff);
      timed_out    = elapsed_next > timeout_ff;

      left_in   = '0;
      right_in  = '0;
      status_in = ddps_pkg::STATUS_RUNNING;
      if (op_ff == ddps_pkg::OP_START) begin
         status_in = ddps_pkg::STATUS_RUNNING;
      end else if (!active_ff) begin
         status_in = ddps_pkg::STATUS_IDLE;
      end else if (settled) begin
         status_in = ddps_pkg::STATUS_SETTLED;
      end else if (timed_out) begin
         status_in = ddps_pkg::STATUS_TIMED_OUT;
      end else if (curve_right_ff) begin
         left_in  = ddps_pkg::sat127(other);
         right_in = ddps_pkg::sat127(curved);
      end else begin
         left_in  = ddps_pkg::sat127(curved);
         right_in = ddps_pkg::sat127(other);
      end
   end

   // move state
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff     <= '0;
         last_ff     <= '0;
         band_cnt_ff <= '0;
         elapsed_ff  <= '0;
         active_ff   <= 1'b0;
      end else if (cmd.finish) begin
         if (op_ff == ddps_pkg::OP_START) begin
            zero_ff     <= enc_ff;
            last_ff     <= '0;
            band_cnt_ff <= '0;
            elapsed_ff  <= '0;
            active_ff   <= 1'b1;
         end else if (active_ff) begin
            last_ff     <= err_ff;
            band_cnt_ff <= in_band ? cnt_next : 6'd0;
            elapsed_ff  <= elapsed_next;
            if (settled || timed_out) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_op;
         enc_ff <= req_encoder_degrees;
      end
      if (cmd.step_mag) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (cmd.step_lo || cmd.step_hi || cmd.step_kp) begin
         prod_ff <= prod_in;
      end
      if (cmd.step_hi) begin
         lo_sh_ff <= prod_ff[35:16];
      end
      if (cmd.step_pos) begin
         pos_ff <= pos_in;
      end
      if (cmd.step_err) begin
         err_ff <= err_in;
      end
      if (cmd.step_sum) begin
         power_ff <= power_in;
      end
      if (cmd.finish) begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         status_ff <= status_in;
      end
   end

endmodule

@@ sv/ddps_checker.sv @@
module ddps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [7:0] rsp_left_power,
   input logic signed [7:0] rsp_right_power,
   input logic [1:0]        rsp_status
);

   // a waiting response beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_power)
         && $stable(rsp_right_power) && $stable(rsp_status))
      else $error("response beat changed while stalled");

   // output register empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // anything but a running status brakes both sides
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ddps_pkg::STATUS_RUNNING)
         |-> rsp_left_power == 8'sd0 && rsp_right_power == 8'sd0)
      else $error("power not zero on non-running status");

   // powers saturate to plus or minus 127
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_power != -8'sd128 && rsp_right_power != -8'sd128)
      else $error("power outside saturation range");

   // one beat at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after accepted beat");

endmodule

bind drive_distance_pd_settle ddps_checker u_ddps_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_left_power      (rsp_left_power),
   .rsp_right_power     (rsp_right_power),
   .rsp_status          (rsp_status)
);

@@ tb/tb_drive_distance_pd_settle.sv @@
`timescale 1ns / 1ps

module tb_drive_distance_pd_settle;

   localparam longint DEG_Q8_SCALE = 585635;
   localparam longint ERR_HI = 33554431;
   localparam longint ERR_LO = -33554432;
   localparam longint BAND_LIMIT = 128;
   localparam logic signed [20:0] ENC_MAX = 21'sh0FFFFF;
   localparam logic signed [20:0] ENC_MIN = 21'sh100000;

   typedef struct packed {
      logic signed [7:0] left;
      logic signed [7:0] right;
      logic [1:0]        status;
   } drive_cmd_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_op;
   logic signed [20:0]               req_encoder_degrees;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic signed [7:0]                rsp_left_power;
   logic signed [7:0]                rsp_right_power;
   logic [1:0]                       rsp_status;
   logic                             csr_wen;
   logic [ddps_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ddps_pkg::CSR_DATA_W-1:0]  csr_wdata;

   // register shadows
   logic signed [23:0] cfg_target;
   logic [6:0]         cfg_max_power;
   logic               cfg_reversed;
   logic [6:0]         cfg_curve;
   logic               cfg_curve_right;
   logic [15:0]        cfg_timeout;
   logic [9:0]         cfg_kp;
   logic [5:0]         cfg_settle;

   // move state of the controller
   logic signed [20:0] ctl_zero;
   longint             ctl_last_err;
   int                 band_cnt;
   int                 elapsed;
   bit                 moving;

   drive_cmd_type expected_cmds[$];
   int send_idle_pct;
   int recv_idle_pct;
   int beats_sent;
   int beats_checked;
   int settled_seen;
   int timeout_seen;
   int idle_seen;
   int error_count;

   drive_distance_pd_settle #(.ENCODER_WIDTH(21)) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_encoder_degrees (req_encoder_degrees),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_power      (rsp_left_power),
      .rsp_right_power     (rsp_right_power),
      .rsp_status          (rsp_status),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic longint clip127(input longint v);
      if (v > 127) begin
         return 127;
      end else if (v < -127) begin
         return -127;
      end
      return v;
   endfunction

   function automatic drive_cmd_type predict_drive(input logic op,
                                                   input logic signed [20:0] enc);
      drive_cmd_type r;
      longint delta, mag, pos, err, sum, power, curved, lp, rp;
      r.left = 8'sd0;
      r.right = 8'sd0;
      r.status = ddps_pkg::STATUS_RUNNING;
      if (op == ddps_pkg::OP_START) begin
         ctl_zero = enc;
         ctl_last_err = 0;
         band_cnt = 0;
         elapsed = 0;
         moving = 1'b1;
         return r;
      end
      if (!moving) begin
         r.status = ddps_pkg::STATUS_IDLE;
         return r;
      end
      delta = longint'(enc) - longint'(ctl_zero);
      mag = (delta < 0) ? -delta : delta;
      mag = (mag * DEG_Q8_SCALE) >>> 16;
      pos = (delta < 0) ? -mag : mag;
      err = longint'(cfg_target) - pos;
      if (err > ERR_HI) err = ERR_HI;
      if (err < ERR_LO) err = ERR_LO;
      sum = longint'(cfg_kp) * err + 256 * (err - ctl_last_err) + 15 * 65536;
      power = sum / 65536 + 20;
      ctl_last_err = err;
      if (power > longint'(cfg_max_power)) power = longint'(cfg_max_power);
      if (cfg_reversed) power = -power;
      // zero power is not positive, so the trimmed side gets +curve
      curved = (power > 0) ? power - longint'(cfg_curve) : power + longint'(cfg_curve);
      if (cfg_curve_right) begin
         lp = power;
         rp = curved;
      end else begin
         lp = curved;
         rp = power;
      end
      lp = clip127(lp);
      rp = clip127(rp);
      if (elapsed < 65535) elapsed++;
      if (err < BAND_LIMIT && err > -BAND_LIMIT) begin
         if (band_cnt < 63) band_cnt++;
         // settling takes priority over a timeout on the same tick
         if (band_cnt >= int'(cfg_settle)) begin
            moving = 1'b0;
            r.status = ddps_pkg::STATUS_SETTLED;
            return r;
         end
      end else begin
         band_cnt = 0;
      end
      if (elapsed > int'(cfg_timeout)) begin
         moving = 1'b0;
         r.status = ddps_pkg::STATUS_TIMED_OUT;
         return r;
      end
      r.left = lp[7:0];
      r.right = rp[7:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) $display("error at %0t ns: %s", $time, what);
   endtask

   task automatic send_beat(input logic op, input logic signed [20:0] enc);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_encoder_degrees <= enc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_cmds.push_back(predict_drive(op, enc));
      beats_sent++;
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ddps_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [23:0] data);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         ddps_pkg::CSR_TARGET:      cfg_target = data;
         ddps_pkg::CSR_MAX_POWER:   cfg_max_power = data[6:0];
         ddps_pkg::CSR_REVERSED:    cfg_reversed = data[0];
         ddps_pkg::CSR_CURVE:       cfg_curve = data[6:0];
         ddps_pkg::CSR_CURVE_RIGHT: cfg_curve_right = data[0];
         ddps_pkg::CSR_TIMEOUT:     cfg_timeout = data[15:0];
         ddps_pkg::CSR_KP:          cfg_kp = data[9:0];
         ddps_pkg::CSR_SETTLE:      cfg_settle = data[5:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [23:0] target, input int max_pwr, input int rev,
                            input int curve, input int cright, input int tmo, input int kp,
                            input int settle);
      write_reg(ddps_pkg::CSR_TARGET, target);
      write_reg(ddps_pkg::CSR_MAX_POWER, 24'(max_pwr));
      write_reg(ddps_pkg::CSR_REVERSED, 24'(rev));
      write_reg(ddps_pkg::CSR_CURVE, 24'(curve));
      write_reg(ddps_pkg::CSR_CURVE_RIGHT, 24'(cright));
      write_reg(ddps_pkg::CSR_TIMEOUT, 24'(tmo));
      write_reg(ddps_pkg::CSR_KP, 24'(kp));
      write_reg(ddps_pkg::CSR_SETTLE, 24'(settle));
   endtask

   task automatic randomize_settings();
      longint tgt;
      int mp, tmo, kp, settle, curve;
      case ($urandom_range(7))
         0: tgt = 8388607;
         1: tgt = -8388608;
         default: tgt = longint'($urandom_range(0, 40000)) - 20000;
      endcase
      if ($urandom_range(3) == 0) mp = $urandom_range(1) ? 127 : 0;
      else mp = $urandom_range(20, 127);
      curve = $urandom_range(1) ? 0 : $urandom_range(0, 127);
      case ($urandom_range(5))
         0: tmo = 0;
         1: tmo = 65535;
         2: tmo = $urandom_range(3, 40);
         default: tmo = 250;
      endcase
      case ($urandom_range(5))
         0: kp = 0;
         1: kp = 1023;
         default: kp = $urandom_range(50, 400);
      endcase
      case ($urandom_range(15))
         0: settle = 63;
         1: settle = 0;
         default: settle = $urandom_range(1, 10);
      endcase
      write_all(tgt[23:0], mp, $urandom_range(1), curve, $urandom_range(1), tmo, kp, settle);
   endtask

   // start beat, ramp toward the target, then hover near it for the settle count plus up to six more ticks
   task automatic run_move();
      longint z, tg, e;
      int ramp, hover, wobble;
      z = longint'($urandom_range(0, 1000000)) - 500000;
      tg = z + (longint'(cfg_target) * 65536) / DEG_Q8_SCALE;
      ramp = $urandom_range(1, 12);
      hover = int'(cfg_settle) + int'($urandom_range(0, 6));
      wobble = ($urandom_range(4) == 0) ? 25 : 13;
      send_beat(ddps_pkg::OP_START, z[20:0]);
      for (int i = 1; i <= ramp + hover; i++) begin
         if (i <= ramp) e = z + (tg - z) * i / ramp + int'($urandom_range(0, 6)) - 3;
         else e = tg + int'($urandom_range(0, 2 * wobble)) - wobble;
         send_beat(ddps_pkg::OP_TICK, e[20:0]);
      end
   endtask

   task automatic test_idle_and_extremes();
      send_beat(ddps_pkg::OP_TICK, 21'sd0);
      send_beat(ddps_pkg::OP_TICK, ENC_MIN);
      send_beat(ddps_pkg::OP_START, ENC_MAX);
      send_beat(ddps_pkg::OP_TICK, ENC_MIN);
      send_beat(ddps_pkg::OP_TICK, ENC_MAX);
      send_beat(ddps_pkg::OP_START, ENC_MIN);
      send_beat(ddps_pkg::OP_TICK, ENC_MAX);
      send_beat(ddps_pkg::OP_TICK, 21'sd0);
      wait_for_responses();
      write_all(24'h7FFFFF, 0, 1, 127, 1, 0, 1023, 63);
      send_beat(ddps_pkg::OP_START, 21'sd0);
      send_beat(ddps_pkg::OP_TICK, 21'sd0);
      send_beat(ddps_pkg::OP_TICK, 21'sd0);
      wait_for_responses();
      write_all(24'h800000, 127, 0, 0, 0, 250, 154, 26);
      send_beat(ddps_pkg::OP_START, 21'sd0);
      send_beat(ddps_pkg::OP_TICK, 21'sd0);
      send_beat(ddps_pkg::OP_TICK, ENC_MAX);
      wait_for_responses();
   endtask

   task automatic test_corner_cases();
      // zero power with a curve on either side
      write_all(24'h000000, 0, 0, 50, 0, 250, 154, 26);
      send_beat(ddps_pkg::OP_START, 21'sd1000);
      send_beat(ddps_pkg::OP_TICK, 21'sd1200);
      wait_for_responses();
      write_reg(ddps_pkg::CSR_CURVE_RIGHT, 24'd1);
      send_beat(ddps_pkg::OP_TICK, 21'sd900);
      wait_for_responses();
      // settle and timeout on the same tick
      write_all(24'h000000, 127, 0, 0, 0, 0, 154, 1);
      send_beat(ddps_pkg::OP_START, 21'sd100);
      send_beat(ddps_pkg::OP_TICK, 21'sd100);
      wait_for_responses();
      // zero settle count
      write_reg(ddps_pkg::CSR_TIMEOUT, 24'd250);
      write_reg(ddps_pkg::CSR_SETTLE, 24'd0);
      send_beat(ddps_pkg::OP_START, 21'sd7);
      send_beat(ddps_pkg::OP_TICK, 21'sd7);
      send_beat(ddps_pkg::OP_TICK, 21'sd7);
      wait_for_responses();
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct, input int n);
      int stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = beats_sent + n;
      while (beats_sent < stop_at) begin
         wait_for_responses();
         randomize_settings();
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4)) send_beat(1'($urandom_range(1)), 21'($urandom));
         end else begin
            run_move();
         end
      end
      wait_for_responses();
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      drive_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         case (rsp_status)
            ddps_pkg::STATUS_SETTLED:   settled_seen++;
            ddps_pkg::STATUS_TIMED_OUT: timeout_seen++;
            ddps_pkg::STATUS_IDLE:      idle_seen++;
            default: ;
         endcase
         if (expected_cmds.size() == 0) begin
            report_mismatch("response beat with nothing expected");
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_left_power !== want.left)
               report_mismatch($sformatf("left_power %0d, expected %0d",
                                         rsp_left_power, want.left));
            if (rsp_right_power !== want.right)
               report_mismatch($sformatf("right_power %0d, expected %0d",
                                         rsp_right_power, want.right));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
         end
      end
   end

   initial begin
      #4000000;
      $display("timeout: run did not complete");
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = ddps_pkg::OP_START;
      req_encoder_degrees = '0;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      beats_sent = 0;
      beats_checked = 0;
      settled_seen = 0;
      timeout_seen = 0;
      idle_seen = 0;
      error_count = 0;
      cfg_target = '0;
      cfg_max_power = ddps_pkg::MAX_POWER_RST;
      cfg_reversed = 1'b0;
      cfg_curve = '0;
      cfg_curve_right = 1'b0;
      cfg_timeout = ddps_pkg::TIMEOUT_RST;
      cfg_kp = ddps_pkg::KP_RST;
      cfg_settle = ddps_pkg::SETTLE_RST;
      ctl_zero = '0;
      ctl_last_err = 0;
      band_cnt = 0;
      elapsed = 0;
      moving = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_and_extremes();
      test_corner_cases();
      test_random_phase(34, 64, 330);
      test_random_phase(64, 34, 330);
      test_random_phase(0, 0, 330);

      wait_for_responses();
      repeat (20) @(posedge clock);
      $display("covered %0d request beats and %0d response beats", beats_sent, beats_checked);
      $display("moves settled %0d, timed out %0d, ticks while idle %0d",
               settled_seen, timeout_seen, idle_seen);
      if (error_count == 0 && expected_cmds.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
